[rtl/lzssw_pkg.sv]
// Package for the LZSS window decompressor: widths, constants and state types.
// Used by the decompressor core; the generic RAM does not depend on it.
`timescale 1ns / 1ps

package lzssw_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int PTR_W       = $clog2(WINDOW_SIZE);
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 16;
    localparam int LEN_W       = 5;
    localparam int REM_W       = 4;
    localparam int MIN_MATCH   = 3;
    localparam int FLAG_COUNT  = 8;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_COPY = 2'b10
    } t_state;

    typedef enum logic [2:0] {
        PH_FLAG = 3'b001,
        PH_ITEM = 3'b010,
        PH_HIGH = 3'b100
    } t_phase;

endpackage

[rtl/lzssw_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Read-first: a read of the address written at the same edge returns the old data.
`timescale 1ns / 1ps

module lzssw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/lzss_window_decompressor_core.sv]
// Top level of the LZSS decompressor with a 4 KiB history ring.
// Depends on lzssw_pkg and the generic RAM lzssw_ram.
`timescale 1ns / 1ps

// Compressed bytes enter one per input beat and decompressed bytes leave one
// per output beat. Flag bytes and the low byte of a match token are only
// accepted; a literal is accepted, then emitted; the high byte of a match token
// is accepted, then its 3 to 18 copied bytes are emitted. The copy rate is
// one byte per cycle, set by the single read port of the 4096 x 8 history RAM,
// and output back-pressure stretches it beat for beat. The history needs no
// clearing pass: since it fills in order from entry zero, an entry counts as
// written when it lies below the write pointer or the ring has wrapped, and
// unwritten entries read as zero. tlast marks the last byte of each literal or
// match, tuser marks the byte that completes total_length.

module lzss_window_decompressor_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // Configuration: total_length.
    input  logic                        i_cfg_we,
    input  logic [lzssw_pkg::CNT_W-1:0] i_cfg_wdata,
    // Input stream.
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [7:0]                  i_s_axis_tdata,  // [7:0] in_byte
    input  logic [0:0]                  i_s_axis_tuser,  // [0] stream_start
    // Output stream.
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [7:0]                  o_m_axis_tdata,  // [7:0] out_byte
    output logic                        o_m_axis_tlast,  // run_last
    output logic [0:0]                  o_m_axis_tuser   // [0] stream_done
);

    localparam int PW = lzssw_pkg::PTR_W;
    localparam int BW = lzssw_pkg::BYTE_W;
    localparam int CW = lzssw_pkg::CNT_W;
    localparam int LW = lzssw_pkg::LEN_W;
    localparam int RW = lzssw_pkg::REM_W;

    lzssw_pkg::t_state r_state, n_state;
    lzssw_pkg::t_phase r_phase, n_phase;

    logic [CW-1:0] r_total;
    logic [PW-1:0] r_wp, n_wp;
    logic          r_wrapped, n_wrapped;
    logic [CW-1:0] r_prod, n_prod;
    logic [BW-1:0] r_flags, n_flags;
    logic [RW-1:0] r_rem, n_rem;
    logic [BW-1:0] r_tok_low, n_tok_low;
    logic [LW-1:0] r_len, n_len;
    logic          r_is_lit, n_is_lit;
    logic [BW-1:0] r_lit, n_lit;
    logic [PW-1:0] r_cur;
    logic          r_fwd_hit;
    logic [BW-1:0] r_fwd_data;

    logic          r_out_valid;
    logic [BW-1:0] r_out_data;
    logic          r_out_last;
    logic          r_out_done;

    logic          in_accept;
    logic          emit;
    logic          entry_valid;
    logic [BW-1:0] copy_byte;
    logic [BW-1:0] rd_data;
    logic [PW-1:0] raddr;
    logic          emit_done;
    logic          emit_last;

    // Working copies of the parse state after an optional stream restart.
    logic [CW-1:0] prod_eff;
    logic [BW-1:0] flags_eff;
    logic [RW-1:0] rem_eff;
    lzssw_pkg::t_phase phase_eff;
    logic [RW-1:0] rem_dec;

    assign o_s_axis_tready = (r_state == lzssw_pkg::ST_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign emit            = (r_state == lzssw_pkg::ST_COPY)
                             && (!r_out_valid || i_m_axis_tready);

    assign entry_valid = r_wrapped || (r_cur < r_wp);

    always_comb begin
        priority if (r_is_lit) begin
            copy_byte = r_lit;
        end else if (!entry_valid) begin
            copy_byte = '0;
        end else if (r_fwd_hit) begin
            copy_byte = r_fwd_data;
        end else begin
            copy_byte = rd_data;
        end
    end

    // The read address leads the byte being emitted, so the registered RAM read returns the entry at r_cur.
    always_comb begin
        unique case (r_state)
            lzssw_pkg::ST_COPY: raddr = emit ? r_cur + PW'(1) : r_cur;
            default:            raddr = {i_s_axis_tdata[3:0], r_tok_low};
        endcase
    end

    lzssw_ram #(
        .WIDTH(BW),
        .DEPTH(lzssw_pkg::WINDOW_SIZE)
    ) u_history (
        .i_clk  (i_clk),
        .i_we   (emit),
        .i_waddr(r_wp),
        .i_wdata(copy_byte),
        .i_raddr(raddr),
        .o_rdata(rd_data)
    );

    assign emit_done = ((r_prod + CW'(1)) == r_total);
    assign emit_last = (r_len == LW'(1)) || emit_done;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_wp      = r_wp;
        n_wrapped = r_wrapped;
        n_prod    = r_prod;
        n_flags   = r_flags;
        n_rem     = r_rem;
        n_tok_low = r_tok_low;
        n_len     = r_len;
        n_is_lit  = r_is_lit;
        n_lit     = r_lit;

        prod_eff  = r_prod;
        flags_eff = r_flags;
        rem_eff   = r_rem;
        phase_eff = r_phase;
        rem_dec   = '0;

        if (in_accept) begin
            if (i_s_axis_tuser[0]) begin
                n_wp      = '0;
                n_wrapped = 1'b0;
                n_prod    = '0;
                n_flags   = '0;
                n_rem     = '0;
                n_phase   = lzssw_pkg::PH_FLAG;
                n_tok_low = '0;
                prod_eff  = '0;
                flags_eff = '0;
                rem_eff   = '0;
                phase_eff = lzssw_pkg::PH_FLAG;
            end
            rem_dec = (rem_eff != '0) ? rem_eff - RW'(1) : rem_eff;

            if (prod_eff < r_total) begin
                unique case (phase_eff)
                    lzssw_pkg::PH_ITEM: begin
                        if (flags_eff[0]) begin
                            n_is_lit = 1'b1;
                            n_lit    = i_s_axis_tdata;
                            n_len    = LW'(1);
                            n_state  = lzssw_pkg::ST_COPY;
                            n_flags  = flags_eff >> 1;
                            n_rem    = rem_dec;
                            n_phase  = (rem_dec == '0) ? lzssw_pkg::PH_FLAG
                                                       : lzssw_pkg::PH_ITEM;
                        end else begin
                            n_tok_low = i_s_axis_tdata;
                            n_phase   = lzssw_pkg::PH_HIGH;
                        end
                    end
                    lzssw_pkg::PH_HIGH: begin
                        n_is_lit = 1'b0;
                        n_len    = LW'(i_s_axis_tdata[7:4]) + LW'(lzssw_pkg::MIN_MATCH);
                        n_state  = lzssw_pkg::ST_COPY;
                        n_flags  = flags_eff >> 1;
                        n_rem    = rem_dec;
                        n_phase  = (rem_dec == '0) ? lzssw_pkg::PH_FLAG
                                                   : lzssw_pkg::PH_ITEM;
                    end
                    default: begin
                        n_flags = i_s_axis_tdata;
                        n_rem   = RW'(lzssw_pkg::FLAG_COUNT);
                        n_phase = lzssw_pkg::PH_ITEM;
                    end
                endcase
            end
        end

        if (emit) begin
            n_wp   = r_wp + PW'(1);
            n_prod = r_prod + CW'(1);
            n_len  = r_len - LW'(1);
            if (r_wp == '1) begin
                n_wrapped = 1'b1;
            end
            if (emit_last) begin
                n_state = lzssw_pkg::ST_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzssw_pkg::ST_IDLE;
            r_phase     <= lzssw_pkg::PH_FLAG;
            r_total     <= '0;
            r_wp        <= '0;
            r_wrapped   <= 1'b0;
            r_prod      <= '0;
            r_flags     <= '0;
            r_rem       <= '0;
            r_tok_low   <= '0;
            r_fwd_hit   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_wp      <= n_wp;
            r_wrapped <= n_wrapped;
            r_prod    <= n_prod;
            r_flags   <= n_flags;
            r_rem     <= n_rem;
            r_tok_low <= n_tok_low;
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            // The RAM returns old data when the entry is written at the read edge.
            r_fwd_hit <= emit && (r_wp == raddr);
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len      <= n_len;
        r_is_lit   <= n_is_lit;
        r_lit      <= n_lit;
        r_cur      <= raddr;
        r_fwd_data <= copy_byte;
        if (emit) begin
            r_out_data <= copy_byte;
            r_out_last <= emit_last;
            r_out_done <= emit_done;
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tlast    = r_out_last;
    assign o_m_axis_tuser[0] = r_out_done;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[0]) |-> o_m_axis_tlast)
        else $error("stream_done beat without tlast");

    a_copy_below_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzssw_pkg::ST_COPY) |-> (r_prod < r_total))
        else $error("copy running with the stream already complete");

    a_fwd_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> entry_valid)
        else $error("forwarded byte for an entry not yet written");

    a_wp_follows_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && !in_accept) |=> (r_wp == $past(r_wp) + PW'(1)))
        else $error("write pointer out of step with emitted bytes");

endmodule
